// ===== design/lzwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared types and fixed constants of the 12-bit LZW compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

  localparam int BYTE_W    = 8;
  localparam int OUT_W     = 12;
  localparam int EPOCH_W   = 8;
  localparam int FIRST_NEW = 256;

  // One classified input transaction as it travels from front to back.
  typedef struct packed {
    logic              start;
    logic              last;
    logic [BYTE_W-1:0] data;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [OUT_W-1:0] code;
    logic             last;
    logic             done;
  } result_t;

endpackage

// ===== design/lzwc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/lzwc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor front end
// Accepts bytes, marks the first byte of each message and queues them.
// ----------------------------------------------------------------------------
module lzwc_front
  import lzwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_input,
  output logic              item_valid,
  output item_t             item,
  input  logic              item_pop
);

  item_t       slots [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        in_message;
  logic        do_push;

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{start: !in_message, last: end_of_input, data: data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= 1'b0;
      wr_ptr     <= 1'b0;
      count      <= 2'd0;
      in_message <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr     <= !wr_ptr;
        in_message <= !end_of_input;
      end
      if (item_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(item_pop);
    end
  end

endmodule

// ===== design/lzwc_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor result queue
// Four-entry queue of result transactions toward the receiver.
// ----------------------------------------------------------------------------
module lzwc_outq
  import lzwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    room2,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    slots [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic       do_pop;

  assign empty  = (count == 3'd0);
  assign do_pop = pop && !empty;
  assign room2  = (count <= 3'd2);
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(res_push) - 3'(do_pop);
    end
  end

endmodule

// ===== design/lzwc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor back end
// Dictionary lookup with linear probing, insertion and code emission.
// ----------------------------------------------------------------------------
module lzwc_back
  import lzwc_pkg::*;
#(
  parameter int CODE_LIMIT = 4096,
  parameter int HASH_SLOTS = 4096
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  input  logic    out_room,
  output logic    res_push,
  output result_t res
);

  localparam int CW    = $clog2(CODE_LIMIT);
  localparam int NW    = $clog2(CODE_LIMIT + 1);
  localparam int HW    = $clog2(HASH_SLOTS);
  localparam int KW    = CW + BYTE_W;
  localparam int ENT_W = EPOCH_W + KW + CW;
  localparam int SW    = CW + 7;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PROBE = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [EPOCH_W-1:0]  epoch, epoch_next;
  logic [CW-1:0]       cur, cur_next;
  logic [NW-1:0]       nfc, nfc_next;
  logic [HW-1:0]       p, p_next;
  logic [HW-1:0]       cnt, cnt_next;
  logic [HW-1:0]       clr, clr_next;
  logic [KW-1:0]       key, key_next;
  logic [BYTE_W-1:0]   byte_r, byte_r_next;
  logic                last_r, last_r_next;

  logic                ram_we;
  logic [HW-1:0]       ram_addr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;

  logic [EPOCH_W-1:0]  d_epoch;
  logic [KW-1:0]       d_key;
  logic [CW-1:0]       d_code;
  logic                slot_empty;
  logic                slot_hit;
  logic                probe_wrap;
  logic [HW-1:0]       p_step;
  logic [SW-1:0]       hsum;
  logic [HW-1:0]       hlow;
  logic [HW-1:0]       home;

  assign d_epoch    = ram_rdata[ENT_W-1 -: EPOCH_W];
  assign d_key      = ram_rdata[CW+KW-1 -: KW];
  assign d_code     = ram_rdata[CW-1:0];
  assign slot_empty = (d_epoch != epoch);
  assign slot_hit   = !slot_empty && (d_key == key);
  assign probe_wrap = (cnt == HW'(HASH_SLOTS - 1));
  assign p_step     = (p == HW'(HASH_SLOTS - 1)) ? '0 : p + HW'(1);

  // Home slot: (prefix * 37 + byte) cut to its low HW bits, then brought into the table with one conditional subtract.
  assign hsum = SW'(cur) * SW'(37) + SW'(item.data);
  assign hlow = HW'(hsum);
  assign home = ({1'b0, hlow} >= (HW+1)'(HASH_SLOTS)) ? hlow - HW'(HASH_SLOTS) : hlow;

  lzwc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HASH_SLOTS)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next  = state;
    epoch_next  = epoch;
    cur_next    = cur;
    nfc_next    = nfc;
    p_next      = p;
    cnt_next    = cnt;
    clr_next    = clr;
    key_next    = key;
    byte_r_next = byte_r;
    last_r_next = last_r;
    item_pop    = 1'b0;
    res_push    = 1'b0;
    res         = '{code: OUT_W'(cur), last: 1'b1, done: 1'b1};
    ram_we      = 1'b0;
    ram_addr    = p;
    ram_wdata   = {epoch, key, nfc[CW-1:0]};

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr;
        ram_wdata = '0;
        if (clr == HW'(HASH_SLOTS - 1)) begin
          state_next = S_IDLE;
          epoch_next = '0;
        end else begin
          clr_next = clr + HW'(1);
        end
      end
      S_IDLE: begin
        if (item_valid && out_room) begin
          if (item.start) begin
            if (epoch == '1) begin
              state_next = S_CLEAR;
              clr_next   = '0;
            end else begin
              item_pop   = 1'b1;
              epoch_next = epoch + EPOCH_W'(1);
              nfc_next   = NW'(FIRST_NEW);
              cur_next   = CW'(item.data);
              if (item.last) begin
                res_push = 1'b1;
                res      = '{code: OUT_W'(item.data), last: 1'b1, done: 1'b1};
              end
            end
          end else begin
            item_pop    = 1'b1;
            key_next    = {cur, item.data};
            byte_r_next = item.data;
            last_r_next = item.last;
            p_next      = home;
            cnt_next    = '0;
            ram_addr    = home;
            state_next  = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (slot_hit) begin
          cur_next   = d_code;
          state_next = S_IDLE;
          if (last_r) begin
            res_push = 1'b1;
            res      = '{code: OUT_W'(d_code), last: 1'b1, done: 1'b1};
          end
        end else if (slot_empty || probe_wrap) begin
          res_push = 1'b1;
          res      = '{code: OUT_W'(cur), last: !last_r, done: 1'b0};
          if (slot_empty && (nfc < NW'(CODE_LIMIT))) begin
            ram_we   = 1'b1;
            ram_addr = p;
            nfc_next = nfc + NW'(1);
          end
          cur_next   = CW'(byte_r);
          state_next = last_r ? S_FLUSH : S_IDLE;
        end else begin
          p_next   = p_step;
          cnt_next = cnt + HW'(1);
          ram_addr = p_step;
        end
      end
      S_FLUSH: begin
        res_push   = 1'b1;
        res        = '{code: OUT_W'(cur), last: 1'b1, done: 1'b1};
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      epoch <= '0;
      cur   <= '0;
      nfc   <= NW'(FIRST_NEW);
      clr   <= '0;
    end else begin
      state <= state_next;
      epoch <= epoch_next;
      cur   <= cur_next;
      nfc   <= nfc_next;
      clr   <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    p      <= p_next;
    cnt    <= cnt_next;
    key    <= key_next;
    byte_r <= byte_r_next;
    last_r <= last_r_next;
  end

endmodule

// ===== design/lzw_compressor_12bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor, fixed 12-bit codes
// Byte stream in, LZW code stream out, dictionary rebuilt for every message.
// ----------------------------------------------------------------------------
// Usage: the input side is a queue. Write one message byte per transaction
// with push while full is low; end_of_input marks the last byte of a message.
// The result side is a queue too: while empty is low the oldest code sits on
// out_code, last_of_run and message_done, and pop takes it.
// A byte that is not the first of a message goes through S_IDLE, which
// reads its home slot, and S_PROBE, which checks it; each extra linear
// probe stays in S_PROBE, and a miss on the last byte passes through S_FLUSH
// for the flushed code. The first byte of a message needs S_IDLE alone. The
// loop of reads through the one-port dictionary RAM sets this pace.
// Dictionary slots carry an 8-bit message tag, so clearing per message is
// free. After reset, and again once every 255 messages when the tag wraps,
// a clearing pass writes every slot, all HASH_SLOTS of them (4096 by default),
// during which no byte is processed; input bytes still queue up to two deep.
// When the receiver stalls, results pile up in a four-entry queue and the
// back end waits before any byte that could not place both of its results.
// ----------------------------------------------------------------------------
module lzw_compressor_12bit
  import lzwc_pkg::*;
#(
  parameter int CODE_LIMIT = 4096,
  parameter int HASH_SLOTS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_input,
  output logic              empty,
  input  logic              pop,
  output logic [OUT_W-1:0]  out_code,
  output logic              last_of_run,
  output logic              message_done
);

  item_t   item;
  logic    item_valid;
  logic    item_pop;
  logic    out_room;
  logic    res_push;
  result_t res;
  result_t head;

  // Front end: classifies each byte as message start or continuation.
  lzwc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  // Back end: dictionary search, insertion and code emission.
  lzwc_back #(
    .CODE_LIMIT (CODE_LIMIT),
    .HASH_SLOTS (HASH_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_room   (out_room),
    .res_push   (res_push),
    .res        (res)
  );

  // Result queue decouples the back end from a stalling receiver.
  lzwc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .room2    (out_room),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_code     = head.code;
  assign last_of_run  = head.last;
  assign message_done = head.done;

endmodule
